>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/dmhq_pkg.sv
package dmhq_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int MAX_ARITY  = 8;

    localparam int KEY_W     = 32;
    localparam int KIND_W    = 2;
    localparam int ARITY_W   = 4;
    localparam int LIMIT_W   = 9;
    localparam int ENTRIES_W = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int IDX_W    = $clog2(HEAP_DEPTH);
    localparam int CNT_W    = $clog2(HEAP_DEPTH + 1);
    localparam int DW       = $clog2(MAX_ARITY + 1);
    localparam int KCNT_W   = $clog2(MAX_ARITY + 2);
    localparam int CHILD_W  = IDX_W + $clog2(MAX_ARITY) + 1;
    localparam int RECIP_SH = IDX_W + $clog2(MAX_ARITY);
    localparam int RECIP_W  = RECIP_SH + 1;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd2;

    localparam logic REG_ARITY = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic signed [KEY_W-1:0] KEY_EMPTY = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key_in;
    } t_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic                    was_empty;
        logic                    insert_dropped;
        logic [ENTRIES_W-1:0]    entries_now;
    } t_result;

    typedef logic [MAX_ARITY:0][RECIP_W-1:0] t_recip_tab;

    // ceil(2^RECIP_SH / d) by long division, for parent index = (c-1)/d
    function automatic t_recip_tab recip_tab();
        t_recip_tab       tab;
        logic [RECIP_W:0] num;
        logic [RECIP_W:0] rem;
        logic [RECIP_W:0] q;
        tab = '0;
        for (int d = 1; d <= MAX_ARITY; d++) begin
            num = (RECIP_W + 1)'((64'd1 << RECIP_SH) + 64'(d) - 64'd1);
            rem = '0;
            q   = '0;
            for (int i = RECIP_W; i >= 0; i--) begin
                rem = {rem[RECIP_W-1:0], num[i]};
                if (rem >= (RECIP_W + 1)'(d)) begin
                    rem  = rem - (RECIP_W + 1)'(d);
                    q[i] = 1'b1;
                end
            end
            tab[d] = q[RECIP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_recip_tab RECIP_TAB = recip_tab();

endpackage

>>> design/dary_min_heap_queue.sv
// Dropped insert or empty extract/peek: answered from idle. Peek: root read in S_ROOT, then S_PEEK.
// Insert: S_SU_CHK, S_SU_RD, S_SU_CMP per level climbed; stops at the root or at a parent <= key.
// Extract: S_ROOT, S_EX_LAST, S_EX_KEY, then per node S_SD_START, S_SD_RD/S_SD_CMP per child, S_SD_DEC.
// One item in flight; one single-port-read key RAM sets the rate.
// Result: one-cycle o_done strobe, the receiver cannot stall; busy is low in that cycle.
// Reset (synchronous, active low): count 0, arity 2, capacity 256; key RAM not cleared.
module dary_min_heap_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dmhq_pkg::t_item                     i_item,
    output logic                                o_done,
    output dmhq_pkg::t_result                   o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmhq_pkg::PADDR_W-1:0]        paddr,
    input  logic [dmhq_pkg::PDATA_W-1:0]        pwdata,
    output logic [dmhq_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SU_CHK   = 4'd1;
    localparam logic [3:0] S_SU_RD    = 4'd2;
    localparam logic [3:0] S_SU_CMP   = 4'd3;
    localparam logic [3:0] S_ROOT     = 4'd4;
    localparam logic [3:0] S_PEEK     = 4'd5;
    localparam logic [3:0] S_EX_LAST  = 4'd6;
    localparam logic [3:0] S_EX_KEY   = 4'd7;
    localparam logic [3:0] S_SD_START = 4'd8;
    localparam logic [3:0] S_SD_RD    = 4'd9;
    localparam logic [3:0] S_SD_CMP   = 4'd10;
    localparam logic [3:0] S_SD_DEC   = 4'd11;

    localparam int PM_W = dmhq_pkg::IDX_W + dmhq_pkg::RECIP_W;

    logic [3:0]                            r_state, n_state;
    logic [dmhq_pkg::KIND_W-1:0]           r_kind, n_kind;
    logic signed [dmhq_pkg::KEY_W-1:0]     r_key, n_key;
    logic signed [dmhq_pkg::KEY_W-1:0]     r_min, n_min;
    logic signed [dmhq_pkg::KEY_W-1:0]     r_bestv, n_bestv;
    logic [dmhq_pkg::IDX_W-1:0]            r_pos, n_pos;
    logic [dmhq_pkg::IDX_W-1:0]            r_best, n_best;
    logic [dmhq_pkg::IDX_W-1:0]            r_par, n_par;
    logic [dmhq_pkg::CHILD_W-1:0]          r_c, n_c;
    logic [dmhq_pkg::KCNT_W-1:0]           r_k, n_k;
    logic [dmhq_pkg::DW-1:0]               r_d, n_d;
    logic [dmhq_pkg::CNT_W-1:0]            r_count, n_count;
    logic [dmhq_pkg::ARITY_W-1:0]          r_arity;
    logic [dmhq_pkg::LIMIT_W-1:0]          r_max;
    logic                                  r_done, n_done;
    dmhq_pkg::t_result                     r_res, n_res;

    logic                                  w_we;
    logic [dmhq_pkg::IDX_W-1:0]            w_waddr;
    logic [dmhq_pkg::KEY_W-1:0]            w_wdata;
    logic [dmhq_pkg::IDX_W-1:0]            w_raddr;
    logic [dmhq_pkg::KEY_W-1:0]            w_rdata_u;
    logic signed [dmhq_pkg::KEY_W-1:0]     w_rdata;

    logic [dmhq_pkg::DW-1:0]               w_eff_d;
    logic                                  w_full;
    logic [PM_W-1:0]                       w_pm;
    logic [dmhq_pkg::CHILD_W-1:0]          w_c0;
    logic                                  w_cfg_wr;

    assign w_rdata = $signed(w_rdata_u);

    always_comb begin
        if (r_arity == '0) begin
            w_eff_d = dmhq_pkg::DW'(1);
        end else if (32'(r_arity) > dmhq_pkg::MAX_ARITY) begin
            w_eff_d = dmhq_pkg::DW'(dmhq_pkg::MAX_ARITY);
        end else begin
            w_eff_d = dmhq_pkg::DW'(r_arity);
        end
    end

    assign w_full = 32'(r_count) >= ((32'(r_max) > dmhq_pkg::HEAP_DEPTH) ?
                    32'(dmhq_pkg::HEAP_DEPTH) : 32'(r_max));

    assign w_pm = PM_W'(r_pos - 1'b1) * PM_W'(dmhq_pkg::RECIP_TAB[r_d]);
    assign w_c0 = dmhq_pkg::CHILD_W'(r_d) * dmhq_pkg::CHILD_W'(r_pos)
                  + dmhq_pkg::CHILD_W'(1);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_key   = r_key;
        n_min   = r_min;
        n_bestv = r_bestv;
        n_pos   = r_pos;
        n_best  = r_best;
        n_par   = r_par;
        n_c     = r_c;
        n_k     = r_k;
        n_d     = r_d;
        n_count = r_count;
        n_done  = 1'b0;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_key;
        w_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_item.kind;
                    n_key  = i_item.key_in;
                    n_d    = w_eff_d;
                    if (i_item.kind == dmhq_pkg::KIND_INSERT) begin
                        if (w_full) begin
                            n_done = 1'b1;
                            n_res  = '{key_out: '0, was_empty: 1'b0, insert_dropped: 1'b1,
                                       entries_now: dmhq_pkg::ENTRIES_W'(r_count)};
                        end else begin
                            n_pos   = r_count[dmhq_pkg::IDX_W-1:0];
                            n_count = r_count + 1'b1;
                            n_state = S_SU_CHK;
                        end
                    end else if (r_count == '0) begin
                        n_done = 1'b1;
                        n_res  = '{key_out: dmhq_pkg::KEY_EMPTY, was_empty: 1'b1,
                                   insert_dropped: 1'b0, entries_now: '0};
                    end else begin
                        n_state = S_ROOT;
                    end
                end
            end
            S_SU_CHK: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_done  = 1'b1;
                    n_res   = '{key_out: '0, was_empty: 1'b0, insert_dropped: 1'b0,
                                entries_now: dmhq_pkg::ENTRIES_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    n_par   = w_pm[dmhq_pkg::RECIP_SH +: dmhq_pkg::IDX_W];
                    n_state = S_SU_RD;
                end
            end
            S_SU_RD: begin
                w_raddr = r_par;
                n_state = S_SU_CMP;
            end
            S_SU_CMP: begin
                w_we = 1'b1;
                if (w_rdata <= r_key) begin
                    n_done  = 1'b1;
                    n_res   = '{key_out: '0, was_empty: 1'b0, insert_dropped: 1'b0,
                                entries_now: dmhq_pkg::ENTRIES_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    w_wdata = w_rdata_u;
                    n_pos   = r_par;
                    n_state = S_SU_CHK;
                end
            end
            S_ROOT: begin
                w_raddr = '0;
                n_state = (r_kind == dmhq_pkg::KIND_EXTRACT) ? S_EX_LAST : S_PEEK;
            end
            S_PEEK: begin
                n_done  = 1'b1;
                n_res   = '{key_out: w_rdata, was_empty: 1'b0, insert_dropped: 1'b0,
                            entries_now: dmhq_pkg::ENTRIES_W'(r_count)};
                n_state = S_IDLE;
            end
            S_EX_LAST: begin
                n_min   = w_rdata;
                w_raddr = dmhq_pkg::IDX_W'(r_count - 1'b1);
                n_count = r_count - 1'b1;
                n_state = S_EX_KEY;
            end
            S_EX_KEY: begin
                n_key   = w_rdata;
                n_pos   = '0;
                n_state = S_SD_START;
            end
            S_SD_START: begin
                n_c     = w_c0;
                n_k     = dmhq_pkg::KCNT_W'(1);
                n_best  = r_pos;
                n_bestv = r_key;
                n_state = S_SD_RD;
            end
            S_SD_RD: begin
                if ((32'(r_k) > 32'(r_d)) ||
                    (r_c >= dmhq_pkg::CHILD_W'(r_count))) begin
                    n_state = S_SD_DEC;
                end else begin
                    w_raddr = r_c[dmhq_pkg::IDX_W-1:0];
                    n_state = S_SD_CMP;
                end
            end
            S_SD_CMP: begin
                if (w_rdata < r_bestv) begin
                    n_best  = r_c[dmhq_pkg::IDX_W-1:0];
                    n_bestv = w_rdata;
                end
                n_c     = r_c + 1'b1;
                n_k     = r_k + 1'b1;
                n_state = S_SD_RD;
            end
            S_SD_DEC: begin
                w_we = 1'b1;
                if (r_best == r_pos) begin
                    n_done  = 1'b1;
                    n_res   = '{key_out: r_min, was_empty: 1'b0, insert_dropped: 1'b0,
                                entries_now: dmhq_pkg::ENTRIES_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    w_wdata = r_bestv;
                    n_pos   = r_best;
                    n_state = S_SD_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_arity <= dmhq_pkg::ARITY_RESET;
            r_max   <= dmhq_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (w_cfg_wr) begin
                if (paddr[2] == dmhq_pkg::REG_ARITY) begin
                    r_arity <= pwdata[dmhq_pkg::ARITY_W-1:0];
                end else begin
                    r_max <= pwdata[dmhq_pkg::LIMIT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_min   <= n_min;
        r_bestv <= n_bestv;
        r_pos   <= n_pos;
        r_best  <= n_best;
        r_par   <= n_par;
        r_c     <= n_c;
        r_k     <= n_k;
        r_d     <= n_d;
        r_res   <= n_res;
    end

    dmhq_ram #(
        .WIDTH (dmhq_pkg::KEY_W),
        .DEPTH (dmhq_pkg::HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_u)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == dmhq_pkg::REG_LIMIT) ?
                      dmhq_pkg::PDATA_W'(r_max) : dmhq_pkg::PDATA_W'(r_arity);

endmodule

>>> design/dmhq_ram.sv
module dmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/dmhq_chk.sv
`include "assert_macros.svh"

module dmhq_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input dmhq_pkg::t_result o_result
);

    // a result follows an accepted item or the last cycle of work
    `ASSERT_IMP(a_done_cause, o_done, $past(busy) || $past(start))
    `ASSERT_IMP(a_done_idle, o_done, !busy)
    `ASSERT_IMP(a_empty_result, o_done && o_result.was_empty,
        o_result.key_out == dmhq_pkg::KEY_EMPTY && o_result.entries_now == '0)
    `ASSERT_IMP(a_drop_result, o_done && o_result.insert_dropped,
        !o_result.was_empty && o_result.key_out == '0)
    `ASSERT_NXT(a_accept_busy, start && !busy && !o_done, busy || o_done)

endmodule

bind dary_min_heap_queue dmhq_chk u_chk (.*);
